@@ rtl/taylor_position_velocity_predictor_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Taylor position and velocity predictor
// Both macros sample on clk_i and are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TAYLOR_POSITION_VELOCITY_PREDICTOR_DEFINES_SVH
`define TAYLOR_POSITION_VELOCITY_PREDICTOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TPVP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TPVP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tpvp_pkg.sv @@
// ----------------------------------------------------------------------------
// tpvp_pkg
// Shared constants, types and saturating fixed-point helpers of the predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpvp_pkg;

  localparam int FRAC_BITS     = 40;
  localparam int MAX_PARTICLES = 1024;
  localparam int TBL_AW        = $clog2(MAX_PARTICLES);

  localparam int VAL_W  = 64;
  localparam int IDX_W  = 10;
  localparam int AXIS_W = 2;

  // Input tdata layout, lowest bits first.
  localparam int OFF_T0   = IDX_W;
  localparam int OFF_X0   = OFF_T0 + VAL_W;
  localparam int OFF_V    = OFF_X0 + VAL_W;
  localparam int OFF_F    = OFF_V + VAL_W;
  localparam int OFF_J    = OFF_F + VAL_W;
  localparam int IN_BITS  = OFF_J + VAL_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 2 * VAL_W;

  // Pipeline plan: input stage, time difference, scaled times, then three
  // multiply-accumulate passes of MUL_STAGES each.
  localparam int MUL_STAGES = 4;
  localparam int ST_MAC1    = 3;
  localparam int ST_MAC2    = ST_MAC1 + MUL_STAGES;
  localparam int ST_MAC3    = ST_MAC2 + MUL_STAGES;
  localparam int NUM_STAGES = ST_MAC3 + MUL_STAGES;

  localparam int APB_AW    = 4;
  localparam int REG_IDX_W = APB_AW - 3;
  localparam logic [REG_IDX_W-1:0] REG_CURRENT_TIME = '0;

  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  typedef logic signed [VAL_W-1:0] fix_t;

  localparam fix_t FIX_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam fix_t FIX_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] RND_HALF = 64'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic valid;
    fix_t stamp;
  } tbl_entry_t;

  // Operands and results that ride alongside the multiply chains.
  typedef struct packed {
    fix_t s;
    fix_t s2;
    fix_t vbase;
    fix_t xbase;
    fix_t vel;
    logic skip;
  } side_t;

  function automatic fix_t sat_add(fix_t a, fix_t b);
    logic [VAL_W:0] sum;
    sum = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (sum[VAL_W] != sum[VAL_W-1]) begin
      return sum[VAL_W] ? FIX_MIN : FIX_MAX;
    end
    return sum[VAL_W-1:0];
  endfunction

  function automatic fix_t sat_sub(fix_t a, fix_t b);
    logic [VAL_W:0] diff;
    diff = {a[VAL_W-1], a} - {b[VAL_W-1], b};
    if (diff[VAL_W] != diff[VAL_W-1]) begin
      return diff[VAL_W] ? FIX_MIN : FIX_MAX;
    end
    return diff[VAL_W-1:0];
  endfunction

  // 1.5 * s rounded to nearest with ties up is floor((3s + 1) / 2).
  function automatic fix_t sat_three_half(fix_t s);
    logic [VAL_W+1:0] t;
    logic [VAL_W:0]   q;
    t = {s[VAL_W-1], s[VAL_W-1], s} + {s[VAL_W-1], s, 1'b0} + (VAL_W+2)'(1);
    q = t[VAL_W+1:1];
    if (q[VAL_W] != q[VAL_W-1]) begin
      return q[VAL_W] ? FIX_MIN : FIX_MAX;
    end
    return q[VAL_W-1:0];
  endfunction

  // Takes the rounded double-width product and scales it back to fix_t.
  function automatic fix_t round_sat(logic [2*VAL_W-1:0] r);
    logic [VAL_W-FRAC_BITS:0] chk;
    chk = r[2*VAL_W-1:FRAC_BITS+VAL_W-1];
    if (!(&chk) && (|chk)) begin
      return r[2*VAL_W-1] ? FIX_MIN : FIX_MAX;
    end
    return r[FRAC_BITS+VAL_W-1:FRAC_BITS];
  endfunction

endpackage

@@ rtl/tpvp_ram.sv @@
// ----------------------------------------------------------------------------
// tpvp_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpvp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/tpvp_fmac.sv @@
// ----------------------------------------------------------------------------
// tpvp_fmac
// Four-stage fixed-point multiply-accumulate: y = sat(c + round_sat(a * b)).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpvp_fmac (
  input  logic                            clk_i,
  input  logic [tpvp_pkg::MUL_STAGES-1:0] en_i,
  input  tpvp_pkg::fix_t                  a_i,
  input  tpvp_pkg::fix_t                  b_i,
  input  tpvp_pkg::fix_t                  c_i,
  output tpvp_pkg::fix_t                  y_o
);

  import tpvp_pkg::*;

  logic signed [32:0] a_lo, b_lo;
  logic signed [31:0] a_hi, b_hi;

  logic [63:0]        pll_q;
  logic signed [64:0] plh_q, phl_q;
  logic signed [63:0] phh_q;
  logic [65:0]        cross_q;
  logic [64:0]        low_q;
  logic [63:0]        hh_q;
  logic [127:0]       prod_q;
  fix_t               c1_q, c2_q, c3_q, y_q;

  assign a_lo = {1'b0, a_i[31:0]};
  assign b_lo = {1'b0, b_i[31:0]};
  assign a_hi = a_i[63:32];
  assign b_hi = b_i[63:32];

  // Partial products (unsigned low halves, signed high halves), sum, accumulate.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pll_q <= a_i[31:0] * b_i[31:0];
      plh_q <= a_lo * b_hi;
      phl_q <= a_hi * b_lo;
      phh_q <= a_hi * b_hi;
      c1_q  <= c_i;
    end
    if (en_i[1]) begin
      cross_q <= {plh_q[64], plh_q} + {phl_q[64], phl_q};
      low_q   <= {1'b0, pll_q} + {1'b0, RND_HALF};
      hh_q    <= phh_q;
      c2_q    <= c1_q;
    end
    if (en_i[2]) begin
      prod_q <= {hh_q, 64'b0} + {{30{cross_q[65]}}, cross_q, 32'b0} + {63'b0, low_q};
      c3_q   <= c2_q;
    end
    if (en_i[3]) begin
      y_q <= sat_add(c3_q, round_sat(prod_q));
    end
  end

  assign y_o = y_q;

endmodule

@@ rtl/taylor_position_velocity_predictor.sv @@
// ----------------------------------------------------------------------------
// taylor_position_velocity_predictor
// Third-order Taylor predictor of one axis of one particle per item. The block
// takes one item per clock while the output does not stall and no table clear
// runs. The position polynomial passes through three chained four-stage
// fixed-point multiply-accumulate passes; stalls on the output only stop the
// stages that hold a waiting result. A table of last prediction times, one
// entry per particle, marks items whose particle is already predicted to
// current_time as skipped. After reset the table is cleared over all
// MAX_PARTICLES (1024) entries, taking register writes but no items meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "taylor_position_velocity_predictor_defines.svh"

module taylor_position_velocity_predictor (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // APB configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tpvp_pkg::APB_AW-1:0]         paddr,
  input  logic [tpvp_pkg::VAL_W-1:0]          pwdata,
  output logic [tpvp_pkg::VAL_W-1:0]          prdata,
  output logic                                pready,
  // Input items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // particle_index, start_time, position_base, velocity_base, force_term,
  // jerk_term, zero padding
  input  logic [tpvp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // axis
  input  logic [tpvp_pkg::AXIS_W-1:0]         s_axis_tuser,
  // Result items
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // predicted_position, predicted_velocity
  output logic [tpvp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // skipped
  output logic                                m_axis_tuser
);

  import tpvp_pkg::*;

  localparam logic [TBL_AW-1:0] CLR_LAST = TBL_AW'(MAX_PARTICLES - 1);

  // Configuration
  fix_t ct_q;
  logic cfg_wr;

  // Pipeline control
  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] en;
  logic                  s_fire;

  // Table and clearing pass
  logic              clr_busy_q;
  logic [TBL_AW-1:0] clr_addr_q;
  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_waddr;
  tbl_entry_t        tbl_wdata;
  tbl_entry_t        tbl_rdata;
  logic              wr_item;
  logic              fwd_d, fwd_q;
  logic              in_table0;
  logic              skip0;

  // Stage 0: captured item
  logic [IDX_W-1:0]  in_idx_q;
  logic [AXIS_W-1:0] in_axis_q;
  fix_t              in_t0_q, in_x0_q, in_v_q, in_f_q, in_j_q;

  // Stage 1: time difference
  fix_t st1_s_q, st1_x0_q, st1_v_q, st1_f_q, st1_j_q;
  logic st1_skip_q;

  // Stage 2: scaled time differences
  fix_t st2_s_q, st2_s1_q, st2_s2_q, st2_x0_q, st2_v_q, st2_f_q, st2_j_q;
  logic st2_skip_q;

  // Multiply-accumulate chain outputs and side data
  fix_t  pos_a, vel_a, pos_b, vel_b, pos_c;
  side_t side_d [ST_MAC1:NUM_STAGES-1];
  side_t side_q [ST_MAC1:NUM_STAGES-1];

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign cfg_wr = psel && penable && pwrite && pready
               && (paddr[APB_AW-1:3] == REG_CURRENT_TIME);
  assign pready = 1'b1;
  assign prdata = (paddr[APB_AW-1:3] == REG_CURRENT_TIME) ? ct_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ct_q <= '0;
    end else if (cfg_wr) begin
      ct_q <= pwdata;
    end
  end

  // --------------------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or its item moves on.
  // --------------------------------------------------------------------------
  always_comb begin
    en[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || m_axis_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0] && !clr_busy_q;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= s_fire;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Prediction-time table
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == CLR_LAST) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign in_table0 = 32'(in_idx_q) < 32'(MAX_PARTICLES);

  // The table read lands in the same cycle as the previous item's write, so a
  // matching write is forwarded; it always records the current time.
  assign skip0 = in_table0 &&
                 (fwd_q || (tbl_rdata.valid && (tbl_rdata.stamp == ct_q)));

  assign wr_item = v_q[0] && en[1] && !skip0 && in_table0 && (in_axis_q == AXIS_Z);
  assign fwd_d   = wr_item && (in_idx_q == s_axis_tdata[IDX_W-1:0]);

  assign tbl_we    = clr_busy_q || wr_item;
  assign tbl_waddr = clr_busy_q ? clr_addr_q : TBL_AW'(in_idx_q);
  always_comb begin
    tbl_wdata.valid = !clr_busy_q;
    tbl_wdata.stamp = ct_q;
  end

  tpvp_ram #(
    .WIDTH ($bits(tbl_entry_t)),
    .DEPTH (MAX_PARTICLES)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (s_fire),
    .raddr_i (TBL_AW'(s_axis_tdata[IDX_W-1:0])),
    .rdata_o (tbl_rdata)
  );

  // --------------------------------------------------------------------------
  // Front stages
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      in_idx_q  <= s_axis_tdata[IDX_W-1:0];
      in_axis_q <= s_axis_tuser;
      in_t0_q   <= s_axis_tdata[OFF_T0 +: VAL_W];
      in_x0_q   <= s_axis_tdata[OFF_X0 +: VAL_W];
      in_v_q    <= s_axis_tdata[OFF_V +: VAL_W];
      in_f_q    <= s_axis_tdata[OFF_F +: VAL_W];
      in_j_q    <= s_axis_tdata[OFF_J +: VAL_W];
      fwd_q     <= fwd_d;
    end
    if (en[1]) begin
      st1_s_q    <= sat_sub(ct_q, in_t0_q);
      st1_skip_q <= skip0;
      st1_x0_q   <= in_x0_q;
      st1_v_q    <= in_v_q;
      st1_f_q    <= in_f_q;
      st1_j_q    <= in_j_q;
    end
    if (en[2]) begin
      st2_s_q    <= st1_s_q;
      st2_s1_q   <= sat_three_half(st1_s_q);
      st2_s2_q   <= sat_add(st1_s_q, st1_s_q);
      st2_skip_q <= st1_skip_q;
      st2_x0_q   <= st1_x0_q;
      st2_v_q    <= st1_v_q;
      st2_f_q    <= st1_f_q;
      st2_j_q    <= st1_j_q;
    end
  end

  // --------------------------------------------------------------------------
  // Horner chains: position s*(s*(s*j + f) + v) + x0,
  // velocity 2s*(1.5s*j + f) + v, which finishes one pass early.
  // --------------------------------------------------------------------------
  tpvp_fmac u_pos_a (
    .clk_i (clk_i),
    .en_i  (en[ST_MAC1 +: MUL_STAGES]),
    .a_i   (st2_s_q),
    .b_i   (st2_j_q),
    .c_i   (st2_f_q),
    .y_o   (pos_a)
  );

  tpvp_fmac u_vel_a (
    .clk_i (clk_i),
    .en_i  (en[ST_MAC1 +: MUL_STAGES]),
    .a_i   (st2_s1_q),
    .b_i   (st2_j_q),
    .c_i   (st2_f_q),
    .y_o   (vel_a)
  );

  tpvp_fmac u_pos_b (
    .clk_i (clk_i),
    .en_i  (en[ST_MAC2 +: MUL_STAGES]),
    .a_i   (side_q[ST_MAC2-1].s),
    .b_i   (pos_a),
    .c_i   (side_q[ST_MAC2-1].vbase),
    .y_o   (pos_b)
  );

  tpvp_fmac u_vel_b (
    .clk_i (clk_i),
    .en_i  (en[ST_MAC2 +: MUL_STAGES]),
    .a_i   (side_q[ST_MAC2-1].s2),
    .b_i   (vel_a),
    .c_i   (side_q[ST_MAC2-1].vbase),
    .y_o   (vel_b)
  );

  tpvp_fmac u_pos_c (
    .clk_i (clk_i),
    .en_i  (en[ST_MAC3 +: MUL_STAGES]),
    .a_i   (side_q[ST_MAC3-1].s),
    .b_i   (pos_b),
    .c_i   (side_q[ST_MAC3-1].xbase),
    .y_o   (pos_c)
  );

  always_comb begin
    side_d[ST_MAC1].s     = st2_s_q;
    side_d[ST_MAC1].s2    = st2_s2_q;
    side_d[ST_MAC1].vbase = st2_v_q;
    side_d[ST_MAC1].xbase = st2_x0_q;
    side_d[ST_MAC1].vel   = '0;
    side_d[ST_MAC1].skip  = st2_skip_q;
    for (int k = ST_MAC1 + 1; k < NUM_STAGES; k++) begin
      side_d[k] = side_q[k-1];
    end
    // The velocity leaves its chain here and rides along to the output.
    side_d[ST_MAC3].vel = vel_b;
  end

  always_ff @(posedge clk_i) begin
    for (int k = ST_MAC1; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        side_q[k] <= side_d[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output
  // --------------------------------------------------------------------------
  assign m_axis_tvalid = v_q[NUM_STAGES-1];
  assign m_axis_tuser  = side_q[NUM_STAGES-1].skip;
  assign m_axis_tdata  = side_q[NUM_STAGES-1].skip ? '0
                       : {side_q[NUM_STAGES-1].vel, pos_c};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `TPVP_ASSERT_NEXT(a_accept_enters, s_fire, v_q[0], "accepted item missing from first stage")
  `TPVP_ASSERT_NOW(a_no_item_write_in_clear, clr_busy_q, !wr_item, "table write during clear")
  `TPVP_ASSERT_NOW(a_fwd_skips, v_q[0] && fwd_q && in_table0, skip0, "forwarded entry not skipped")
  `TPVP_ASSERT_NOW(a_clear_full, $fell(clr_busy_q), $past(clr_addr_q) == CLR_LAST, "short clear")

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the Taylor position and velocity predictor
// Streams one-axis particle items into the block and checks every result
// against a cycle-free model of the fixed-point polynomials and the table of
// last prediction times. Directed items cover the field extremes, rounding
// ties, saturation and the skip rules. Random phases then run with and
// without gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import tpvp_pkg::*;

  localparam int LATENCY   = 16;
  localparam int PHASE_LEN = 262;

  localparam logic [AXIS_W-1:0] AXIS_X      = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y      = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_UNUSED = 2'd3;

  localparam logic [APB_AW-1:0] ADDR_CURRENT_TIME = APB_AW'(REG_CURRENT_TIME) << 3;

  localparam fix_t ONE          = fix_t'(1) << FRAC_BITS;
  localparam fix_t HALF_LSB     = fix_t'(1) << (FRAC_BITS - 1);
  localparam fix_t THREE_HALVES = fix_t'(3) << (FRAC_BITS - 1);

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [AXIS_W-1:0] axis;
    fix_t              t0;
    fix_t              x0;
    fix_t              vel;
    fix_t              half_force;
    fix_t              jerk;
  } particle_axis_t;

  typedef struct packed {
    fix_t position;
    fix_t velocity;
    logic skipped;
  } prediction_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [APB_AW-1:0]      paddr   = '0;
  logic [VAL_W-1:0]       pwdata  = '0;
  logic [VAL_W-1:0]       prdata;
  logic                   pready;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // particle_index, start_time, position_base, velocity_base, force_term,
  // jerk_term, zero padding
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  // axis
  logic [AXIS_W-1:0]      s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // predicted_position, predicted_velocity
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // skipped
  logic                   m_axis_tuser;

  taylor_position_velocity_predictor uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // Model state: target time and the table of last prediction times.
  fix_t        target_time = '0;
  fix_t        stamp_time  [MAX_PARTICLES];
  logic        stamp_valid [MAX_PARTICLES];
  prediction_t pending_predictions[$];
  bit          failed = 1'b0;
  int          sender_idle_pct = 0;
  int          ready_stall_pct = 0;

  initial begin
    for (int i = 0; i < MAX_PARTICLES; i++) begin
      stamp_valid[i] = 1'b0;
      stamp_time[i]  = FIX_MIN;
    end
  end

  function automatic fix_t add_sat(fix_t a, fix_t b);
    logic [VAL_W:0] sum;
    sum = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (sum[VAL_W] != sum[VAL_W-1]) return sum[VAL_W] ? FIX_MIN : FIX_MAX;
    return sum[VAL_W-1:0];
  endfunction

  function automatic fix_t sub_sat(fix_t a, fix_t b);
    logic [VAL_W:0] diff;
    diff = {a[VAL_W-1], a} - {b[VAL_W-1], b};
    if (diff[VAL_W] != diff[VAL_W-1]) return diff[VAL_W] ? FIX_MIN : FIX_MAX;
    return diff[VAL_W-1:0];
  endfunction

  // Full 128-bit product, rounded half up at the binary point, then clamped.
  function automatic fix_t mul_round_sat(fix_t a, fix_t b);
    logic signed [2*VAL_W-1:0]     prod;
    logic [VAL_W-FRAC_BITS:0]      head;
    prod = $signed({{VAL_W{a[VAL_W-1]}}, a}) * $signed({{VAL_W{b[VAL_W-1]}}, b});
    prod = prod + ((2*VAL_W)'(1) << (FRAC_BITS - 1));
    head = prod[2*VAL_W-1:VAL_W+FRAC_BITS-1];
    if (head != '0 && head != '1) return prod[2*VAL_W-1] ? FIX_MIN : FIX_MAX;
    return prod[VAL_W+FRAC_BITS-1:FRAC_BITS];
  endfunction

  function automatic prediction_t predict_axis(particle_axis_t it);
    prediction_t r;
    fix_t        s;
    fix_t        s_three_half;
    fix_t        s_double;
    fix_t        acc;
    fix_t        vacc;
    if (stamp_valid[it.idx] && stamp_time[it.idx] == target_time) begin
      r.position = '0;
      r.velocity = '0;
      r.skipped  = 1'b1;
      return r;
    end
    s            = sub_sat(target_time, it.t0);
    s_three_half = mul_round_sat(s, THREE_HALVES);
    s_double     = add_sat(s, s);
    acc  = add_sat(it.half_force, mul_round_sat(s, it.jerk));
    acc  = add_sat(it.vel, mul_round_sat(s, acc));
    acc  = add_sat(it.x0, mul_round_sat(s, acc));
    vacc = add_sat(it.half_force, mul_round_sat(s_three_half, it.jerk));
    vacc = add_sat(it.vel, mul_round_sat(s_double, vacc));
    if (it.axis == AXIS_Z) begin
      stamp_time[it.idx]  = target_time;
      stamp_valid[it.idx] = 1'b1;
    end
    r.position = acc;
    r.velocity = vacc;
    r.skipped  = 1'b0;
    return r;
  endfunction

  function automatic fix_t rand_value();
    logic [VAL_W-1:0] r;
    int               pick;
    r    = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 60) return $signed(r) >>> $urandom_range(14, 40);
    if (pick < 85) return r;
    case ($urandom_range(0, 5))
      0: return FIX_MIN;
      1: return FIX_MAX;
      2: return '0;
      3: return fix_t'(-1);
      4: return ONE;
      default: return HALF_LSB;
    endcase
  endfunction

  // Mostly a base time a little off the target, so results stay in range.
  function automatic fix_t rand_start_time();
    logic [VAL_W-1:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 70) return target_time - ($signed(r) >>> $urandom_range(20, 46));
    return rand_value();
  endfunction

  function automatic particle_axis_t rand_item(logic [IDX_W-1:0] idx, logic [AXIS_W-1:0] axis);
    particle_axis_t it;
    it.idx        = idx;
    it.axis       = axis;
    it.t0         = rand_start_time();
    it.x0         = rand_value();
    it.vel        = rand_value();
    it.half_force = rand_value();
    it.jerk       = rand_value();
    return it;
  endfunction

  // valid stays high on return so that a following item goes out back to back;
  // anything else that lets time pass lowers it first.
  task automatic push_item(particle_axis_t it);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({it.jerk, it.half_force, it.vel, it.x0, it.t0, it.idx});
    s_axis_tuser  <= it.axis;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_predictions.push_back(predict_axis(it));
  endtask

  task automatic wait_until_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_predictions.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  // Waits until the block is idle, then writes, reads back and updates the model.
  task automatic set_target_time(fix_t value);
    logic [VAL_W-1:0] readback;
    wait_until_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_CURRENT_TIME;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    target_time = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== value) begin
      $error("current_time: expected %h, actual %h", value, readback);
      failed = 1'b1;
    end
  endtask

  task automatic test_extreme_fields();
    set_target_time('0);
    push_item('{10'd0, AXIS_X, '0, '0, '0, '0, '0});
    push_item('{10'd1023, AXIS_Y, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX});
    push_item('{10'd5, AXIS_UNUSED, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN});
    // One LSB of elapsed time against plus and minus one half: rounding ties.
    push_item('{10'd6, AXIS_X, fix_t'(-1), '0, '0, '0, HALF_LSB});
    push_item('{10'd6, AXIS_Y, fix_t'(-1), '0, '0, '0, -HALF_LSB});
    push_item('{10'd8, AXIS_X, fix_t'(-1), HALF_LSB, -HALF_LSB, HALF_LSB, '0});
    push_item('{10'd9, AXIS_Z, -(ONE <<< 1), ONE, -ONE, ONE >>> 1, -(ONE >>> 2)});
    push_item('{10'd10, AXIS_X, -ONE, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX});
    push_item('{10'd11, AXIS_Y, ONE, FIX_MIN, FIX_MIN, FIX_MAX, FIX_MIN});
  endtask

  task automatic test_skip_rules();
    // The model's reset table reads as the most negative time but is not valid yet.
    set_target_time(FIX_MIN);
    push_item(rand_item(10'd7, AXIS_X));
    push_item(rand_item(10'd7, AXIS_Y));
    push_item(rand_item(10'd7, AXIS_Z));
    push_item(rand_item(10'd7, AXIS_X));
    push_item(rand_item(10'd7, AXIS_Y));
    push_item(rand_item(10'd7, AXIS_Z));
    // The fourth axis value is predicted but leaves the table alone.
    push_item(rand_item(10'd12, AXIS_UNUSED));
    push_item(rand_item(10'd12, AXIS_X));
    set_target_time(FIX_MAX);
    push_item(rand_item(10'd7, AXIS_X));
    push_item(rand_item(10'd1023, AXIS_Z));
    push_item(rand_item(10'd1023, AXIS_X));
  endtask

  task automatic test_random_stream(int idle_pct, int stall_pct);
    int               sent;
    int               pool_base;
    logic [IDX_W-1:0] idx;
    fix_t             prev_time;
    for (int round = 0; round < 4; round++) begin
      prev_time = target_time;
      wait_until_idle();
      sender_idle_pct = idle_pct;
      ready_stall_pct = stall_pct;
      case ($urandom_range(0, 5))
        0: set_target_time(FIX_MAX);
        1: set_target_time(FIX_MIN);
        2: set_target_time(prev_time);
        3: set_target_time('0);
        default: set_target_time($signed({$urandom, $urandom}) >>> $urandom_range(0, 30));
      endcase
      // Small pools that overlap across rounds make particles come back often.
      pool_base = $urandom_range(0, 1) ? 16 * $urandom_range(0, 3) : $urandom_range(0, 1008);
      sent = 0;
      while (sent < PHASE_LEN / 4) begin
        if ($urandom_range(0, 99) < 70) idx = IDX_W'(pool_base + $urandom_range(0, 15));
        else idx = IDX_W'($urandom_range(0, MAX_PARTICLES - 1));
        if ($urandom_range(0, 99) < 85) begin
          push_item(rand_item(idx, AXIS_X));
          push_item(rand_item(idx, AXIS_Y));
          push_item(rand_item(idx, AXIS_Z));
          sent += 3;
        end else begin
          push_item(rand_item(idx, AXIS_W'($urandom_range(0, 3))));
          sent += 1;
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= ready_stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    prediction_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_predictions.size() == 0) begin
        $error("result item with no prediction pending");
        failed = 1'b1;
      end else begin
        want = pending_predictions.pop_front();
        if (m_axis_tdata[VAL_W-1:0] !== want.position) begin
          $error("predicted_position: expected %h, actual %h",
                 want.position, m_axis_tdata[VAL_W-1:0]);
          failed = 1'b1;
        end
        if (m_axis_tdata[2*VAL_W-1:VAL_W] !== want.velocity) begin
          $error("predicted_velocity: expected %h, actual %h",
                 want.velocity, m_axis_tdata[2*VAL_W-1:VAL_W]);
          failed = 1'b1;
        end
        if (m_axis_tuser !== want.skipped) begin
          $error("skipped: expected %b, actual %b", want.skipped, m_axis_tuser);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extreme_fields();
    test_skip_rules();
    test_random_stream(0, 0);
    test_random_stream(54, 0);
    test_random_stream(0, 54);
    test_random_stream(35, 35);
    s_axis_tvalid <= 1'b0;
    while (pending_predictions.size() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);
    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("simulation failed");
    $finish;
  end

endmodule
